>>> rtl/b64d_pkg.sv
// shared types, constants and the symbol table of the base64 decoder
`default_nettype none

package b64d_pkg;

    // field widths
    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned SYM_W        = 7;
    localparam int unsigned MAX_W        = 24;
    localparam int unsigned CHAR_CNT_W   = 26;
    localparam int unsigned BYTE_CNT_W   = 25;
    localparam int unsigned STATUS_W     = 3;

    // configuration register
    localparam logic [MAX_W-1:0] MAX_DECODED_RESET = 24'd196608;
    localparam logic             REG_IDX_MAX       = 1'b0;

    // symbol codes besides sextets
    localparam logic [SYM_W-1:0] SYM_PAD = 7'd64;
    localparam logic [SYM_W-1:0] SYM_BAD = 7'd127;

    // saturation limits
    localparam logic [CHAR_CNT_W-1:0] CHAR_CNT_MAX = '1;
    localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX = '1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_DATA   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_PAD    = 3'd4;

    // work queue between front and back, power of two depth
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } b64d_in_t;

    typedef struct packed {
        logic                kind;
        logic [7:0]          data_byte;
        logic [STATUS_W-1:0] status;
        logic                last;
    } b64d_out_t;

    // one queue entry: emitted bytes (prefix), optional end status
    typedef struct packed {
        logic [2:0][7:0]     bytes;
        logic [1:0]          n_bytes;
        logic                has_status;
        logic [STATUS_W-1:0] status;
    } b64d_work_t;

    // ascii to symbol: 0..63 sextet, pad, or bad
    function automatic logic [SYM_W-1:0] sym_of(input logic [CHAR_W-1:0] c);
        logic [SYM_W-1:0] s;
        if (c >= 8'd65 && c <= 8'd90) begin
            s = SYM_W'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            s = SYM_W'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            s = SYM_W'(c + 8'd4);
        end else if (c == 8'd43) begin
            s = 7'd62;
        end else if (c == 8'd47) begin
            s = 7'd63;
        end else if (c == 8'd61) begin
            s = SYM_PAD;
        end else begin
            s = SYM_BAD;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64d_front.sv
// front end: symbol classification, group checks, counters and work entries
`default_nettype none

module b64d_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire b64d_pkg::b64d_in_t          s_word,
    input  wire logic [b64d_pkg::MAX_W-1:0]  max_bytes,
    input  wire logic                        q_full,
    output logic                             q_push,
    output b64d_pkg::b64d_work_t             q_entry
);
    import b64d_pkg::*;

    logic [1:0]            pos_reg, pos_next;
    logic [SYM_W-1:0]      hold_reg [3];
    logic [CHAR_CNT_W-1:0] char_cnt_reg, char_cnt_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [STATUS_W-1:0]   first_err_reg, first_err_next;

    logic                  fire;
    logic [SYM_W-1:0]      sym, a, b, t, f;
    logic                  sx_a, sx_b, sx_t, sx_f;
    logic                  group_done;
    logic [STATUS_W-1:0]   err;
    logic [1:0]            n_avail, n_emit;
    logic [2:0]            en;
    logic [BYTE_CNT_W:0]   byte_sum;
    logic [1:0]            pad;
    logic [MAX_W-1:0]      groups;
    logic [CHAR_CNT_W-1:0] size;
    logic [STATUS_W-1:0]   end_status;
    logic [7:0]            byte0, byte1, byte2;

    assign s_ready = !q_full;
    assign fire    = s_valid && !q_full;

    always_comb begin
        sym  = sym_of(s_word.char_code);
        a    = hold_reg[0];
        b    = hold_reg[1];
        t    = hold_reg[2];
        f    = sym;
        sx_a = !a[6];
        sx_b = !b[6];
        sx_t = !t[6];
        sx_f = !f[6];
        group_done = (pos_reg == 2'd3);

        // data check before padding check
        err = ST_OK;
        if (!sx_a || !sx_b || (!s_word.is_last && (!sx_t || !sx_f))) begin
            err = ST_BAD_DATA;
        end else if (!sx_t) begin
            if (t != SYM_PAD || f != SYM_PAD || b[3:0] != 4'd0) begin
                err = ST_BAD_PAD;
            end
        end else if (!sx_f) begin
            if (f != SYM_PAD || t[1:0] != 2'd0) begin
                err = ST_BAD_PAD;
            end
        end

        byte0   = {a[5:0], b[5:4]};
        byte1   = {b[3:0], t[5:2]};
        byte2   = {t[1:0], f[5:0]};
        n_avail = 2'd1 + 2'(sx_t) + 2'(sx_f);

        // bytes below the limit form a prefix of the group
        for (int i = 0; i < 3; i++) begin
            en[i] = group_done && (err == ST_OK) && (first_err_reg == ST_OK) &&
                    (2'(i) < n_avail) &&
                    (({1'b0, byte_cnt_reg} + (BYTE_CNT_W+1)'(i)) <
                     (BYTE_CNT_W+1)'(max_bytes));
        end
        n_emit = 2'(en[0]) + 2'(en[1]) + 2'(en[2]);

        byte_sum = {1'b0, byte_cnt_reg} + (BYTE_CNT_W+1)'(n_avail);
        byte_cnt_next = byte_cnt_reg;
        if (group_done && err == ST_OK) begin
            byte_cnt_next = byte_sum[BYTE_CNT_W] ? BYTE_CNT_MAX : byte_sum[BYTE_CNT_W-1:0];
        end

        char_cnt_next = (char_cnt_reg == CHAR_CNT_MAX) ? char_cnt_reg : char_cnt_reg + 1'b1;

        first_err_next = first_err_reg;
        if (group_done && err != ST_OK && first_err_reg == ST_OK) begin
            first_err_next = err;
        end

        pos_next = group_done ? 2'd0 : pos_reg + 2'd1;

        // trailing pad count of the final group
        pad = 2'd0;
        if (sym == SYM_PAD) begin
            pad = (t == SYM_PAD) ? 2'd2 : 2'd1;
        end
        groups = char_cnt_next[CHAR_CNT_W-1:2];
        size   = {1'b0, groups, 1'b0} + {2'b0, groups} - CHAR_CNT_W'(pad);

        if (pos_next != 2'd0) begin
            end_status = ST_BAD_LENGTH;
        end else if (size > CHAR_CNT_W'(max_bytes)) begin
            end_status = ST_TOO_LARGE;
        end else begin
            end_status = first_err_next;
        end
    end

    always_comb begin
        q_push             = fire && (n_emit != 2'd0 || s_word.is_last);
        q_entry.bytes      = {byte2, byte1, byte0};
        q_entry.n_bytes    = n_emit;
        q_entry.has_status = s_word.is_last;
        q_entry.status     = end_status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 2'd0;
            char_cnt_reg  <= '0;
            byte_cnt_reg  <= '0;
            first_err_reg <= ST_OK;
        end else if (fire) begin
            if (s_word.is_last) begin
                pos_reg       <= 2'd0;
                char_cnt_reg  <= '0;
                byte_cnt_reg  <= '0;
                first_err_reg <= ST_OK;
            end else begin
                pos_reg       <= pos_next;
                char_cnt_reg  <= char_cnt_next;
                byte_cnt_reg  <= byte_cnt_next;
                first_err_reg <= first_err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && !group_done) begin
            hold_reg[pos_reg] <= sym;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64d_queue.sv
// small work queue between front and back
`default_nettype none

module b64d_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire b64d_pkg::b64d_work_t  push_entry,
    input  wire logic                  pop,
    output b64d_pkg::b64d_work_t       head,
    output logic                       empty,
    output logic                       full
);
    import b64d_pkg::*;

    b64d_work_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64d_back.sv
// back end: unpacks queue entries into result words, output register
`default_nettype none

module b64d_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire b64d_pkg::b64d_work_t  head,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output b64d_pkg::b64d_out_t        m_word
);
    import b64d_pkg::*;

    logic [1:0] idx_reg;
    logic       m_valid_reg;
    b64d_out_t  m_word_reg, word_next;
    logic       load;
    logic [2:0] total_m1;
    logic       entry_done;

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    always_comb begin
        load       = !q_empty && (!m_valid_reg || m_ready);
        total_m1   = 3'(head.n_bytes) + 3'(head.has_status) - 3'd1;
        entry_done = (idx_reg == total_m1[1:0]);
        q_pop      = load && entry_done;

        if (idx_reg < head.n_bytes) begin
            word_next.kind      = 1'b0;
            word_next.data_byte = head.bytes[idx_reg];
            word_next.status    = ST_OK;
            word_next.last      = 1'b0;
        end else begin
            word_next.kind      = 1'b1;
            word_next.data_byte = 8'd0;
            word_next.status    = head.status;
            word_next.last      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= entry_done ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/strict_base64_stream_decoder.sv
// top level: strict base64 stream decoder with apb configuration
// a character's first result word passes through the work queue and then the output register
// throughput: one input word per cycle while the queue is not full, one result word per cycle while m_ready is high
// each character's results (0 to 4 words) drain one per cycle, unless the output stalls, from a 4-entry work queue
// input stalls while that queue is full: output held back, or a group's words still draining
// reset: synchronous active low aresetn clears string state and queue, max size to 196608
`default_nettype none

module strict_base64_stream_decoder (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // character input
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire b64d_pkg::b64d_in_t   s_word,
    // decoded output
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output b64d_pkg::b64d_out_t       m_word,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import b64d_pkg::*;

    // max decoded size register
    logic [MAX_W-1:0] max_bytes_reg;
    logic             cfg_wr;

    // queue hookup
    logic       q_push, q_pop, q_empty, q_full;
    b64d_work_t q_entry, q_head;

    // apb: always ready, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_MAX);

    always_comb begin
        if (paddr[2] == REG_IDX_MAX) begin
            prdata = {8'd0, max_bytes_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_DECODED_RESET;
        end else if (cfg_wr) begin
            max_bytes_reg <= pwdata[MAX_W-1:0];
        end
    end

    // front: classify each character, check groups, build work entries
    b64d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .max_bytes (max_bytes_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // queue decouples the front from output stalls
    b64d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // back: one result word per cycle into the output register unless it stalls
    b64d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // no entry written into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("work queue overflow");

    // no entry taken from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("work queue underflow");

    // status words carry a defined code and the end marker, data words carry ST_OK and no end marker
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.kind == m_word.last) &&
                    (m_word.kind || m_word.status == ST_OK) &&
                    (m_word.status == ST_OK || m_word.status == ST_BAD_LENGTH ||
                     m_word.status == ST_TOO_LARGE || m_word.status == ST_BAD_DATA ||
                     m_word.status == ST_BAD_PAD))
        else $error("malformed result word");

    // nothing on the output right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

>>> dv/strict_base64_stream_decoder_tb.sv
// self-checking testbench for the strict base64 stream decoder
`timescale 1ns / 100ps

module strict_base64_stream_decoder_tb;
    import b64d_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 5;
    localparam int PHASE_WORDS    = 45;   // random words per register setting
    localparam int N_PHASES       = 6;
    localparam int IDLE_PCT       = 7;
    localparam int HOLD_AT        = 150;  // input word count that starts the long hold-off
    localparam int HOLD_LEN       = 80;
    localparam int DRAIN_GAP      = 8;    // idle wait after the last owed result word
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // symbol codes used while building random strings
    localparam int SYMV_PAD = 64;
    localparam int SYMV_RAW = 256;  // raw character offset, any byte value

    // one row of the directed table; typed rows carry their expected status
    typedef struct packed {
        logic [7:0]          ch;
        logic                lst;
        logic                typed;
        logic [STATUS_W-1:0] st;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    b64d_in_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    b64d_out_t m_word;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // side tags that travel with the word on the input channel
    logic                tag_typed  = 1'b0;
    logic [STATUS_W-1:0] tag_status = ST_OK;

    // shared tb state
    b64d_out_t due_words[$];    // result words still owed by the block
    logic [7:0] text[$];        // current random string
    int  errors      = 0;
    int  words_in    = 0;
    int  idle_cycles = 0;
    logic quiet      = 1'b0;    // no random idling on either side

    // decoder state as the predictor sees it
    logic [1:0]            grp_pos   = '0;
    logic [SYM_W-1:0]      held [3]  = '{default: '0};
    logic [CHAR_CNT_W-1:0] n_chars   = '0;
    logic [BYTE_CNT_W-1:0] n_bytes   = '0;
    logic [STATUS_W-1:0]   first_err = ST_OK;
    logic [MAX_W-1:0]      max_bytes = MAX_DECODED_RESET;

    dir_row_t directed_rows [25] = '{
        // lone character: partial group at end of string
        '{"A", 1'b1, 1'b1, ST_BAD_LENGTH},
        // all-ones bytes, then a final group with double padding
        '{"/", 1'b0, 1'b0, ST_OK}, '{"/", 1'b0, 1'b0, ST_OK},
        '{"/", 1'b0, 1'b0, ST_OK}, '{"/", 1'b0, 1'b0, ST_OK},
        '{"A", 1'b0, 1'b0, ST_OK}, '{"A", 1'b0, 1'b0, ST_OK},
        '{"=", 1'b0, 1'b0, ST_OK}, '{"=", 1'b1, 1'b0, ST_OK},
        // nul in the first group; later 0xff in the final group must not override
        '{8'h00, 1'b0, 1'b1, ST_OK}, '{"A", 1'b0, 1'b1, ST_OK},
        '{"A", 1'b0, 1'b1, ST_OK}, '{"A", 1'b0, 1'b1, ST_OK},
        '{"A", 1'b0, 1'b1, ST_OK}, '{"A", 1'b0, 1'b1, ST_OK},
        '{"A", 1'b0, 1'b1, ST_OK}, '{8'hFF, 1'b1, 1'b1, ST_BAD_DATA},
        // double padding with nonzero leftover bits
        '{"Q", 1'b0, 1'b1, ST_OK}, '{"R", 1'b0, 1'b1, ST_OK},
        '{"=", 1'b0, 1'b1, ST_OK}, '{"=", 1'b1, 1'b1, ST_BAD_PAD},
        // pad in the first position of the final group
        '{"=", 1'b0, 1'b1, ST_OK}, '{"A", 1'b0, 1'b1, ST_OK},
        '{"A", 1'b0, 1'b1, ST_OK}, '{"A", 1'b1, 1'b1, ST_BAD_DATA}
    };

    strict_base64_stream_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ascii to symbol: sextet 0..63, pad, or bad
    function automatic logic [SYM_W-1:0] symbol_for(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return SYM_W'(c - "A");
        if (c >= "a" && c <= "z") return SYM_W'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9") return SYM_W'(c - "0" + 8'd52);
        if (c == "+") return SYM_W'(62);
        if (c == "/") return SYM_W'(63);
        if (c == "=") return SYM_PAD;
        return SYM_BAD;
    endfunction

    // sextet to its alphabet character, used to encode random strings
    function automatic logic [7:0] char_for(input int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    // decode one accepted character, appending the result words it causes
    function automatic void decode_char(input b64d_in_t w, ref b64d_out_t dst[$]);
        logic [SYM_W-1:0]    s, a, b, t;
        logic [STATUS_W-1:0] err, fin;
        logic [7:0]          dec [3];
        logic [31:0]         size;
        int                  nb, i;

        s = symbol_for(w.char_code);
        if (n_chars != CHAR_CNT_MAX) n_chars++;

        if (grp_pos != 2'd3) begin
            held[grp_pos] = s;
            grp_pos++;
        end else begin
            a = held[0];
            b = held[1];
            t = held[2];
            // bit 6 set means pad or bad, i.e. not a sextet
            err = ST_OK;
            if (a[6] || b[6] || (!w.is_last && (t[6] || s[6]))) begin
                err = ST_BAD_DATA;
            end else if (t[6]) begin
                if (t != SYM_PAD || s != SYM_PAD || b[3:0] != 4'h0) err = ST_BAD_PAD;
            end else if (s[6]) begin
                if (s != SYM_PAD || t[1:0] != 2'b00) err = ST_BAD_PAD;
            end
            if (err != ST_OK && first_err == ST_OK) first_err = err;

            if (err == ST_OK) begin
                nb = 1 + (t[6] ? 0 : 1) + (s[6] ? 0 : 1);
                dec[0] = {a[5:0], b[5:4]};
                dec[1] = {b[3:0], t[5:2]};
                dec[2] = {t[1:0], s[5:0]};
                for (i = 0; i < nb; i++) begin
                    // bytes past the size limit are counted but not sent
                    if (first_err == ST_OK && n_bytes < max_bytes)
                        dst.insert(dst.size(), b64d_out_t'{KIND_DATA, dec[i], ST_OK, 1'b0});
                    if (n_bytes != BYTE_CNT_MAX) n_bytes++;
                end
            end
            grp_pos = '0;
        end

        if (w.is_last) begin
            if (grp_pos != 2'd0) begin
                fin = ST_BAD_LENGTH;
            end else begin
                size = 32'(n_chars / 4) * 3;
                if (s == SYM_PAD) size -= (held[2] == SYM_PAD) ? 2 : 1;
                fin = (size > max_bytes) ? ST_TOO_LARGE : first_err;
            end
            dst.insert(dst.size(), b64d_out_t'{KIND_STATUS, 8'h00, fin, 1'b1});
            grp_pos   = '0;
            n_chars   = '0;
            n_bytes   = '0;
            first_err = ST_OK;
        end
    endfunction

    // random string: mostly well-formed base64, some broken, some pure noise
    function automatic void build_string();
        int sym[$];
        int pick, nraw, i, left, cut, last_i;
        logic [7:0] b0, b1, b2;

        text.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6)) text.insert(text.size(), 8'($urandom_range(255)));
            return;
        end

        // mostly short strings, a few long ones to hit the size limit
        nraw = ($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
        for (i = 0; i < nraw; i += 3) begin
            left = nraw - i;
            b0 = 8'($urandom_range(255));
            b1 = (left > 1) ? 8'($urandom_range(255)) : 8'h00;
            b2 = (left > 2) ? 8'($urandom_range(255)) : 8'h00;
            sym.insert(sym.size(), int'(b0[7:2]));
            sym.insert(sym.size(), int'({b0[1:0], b1[7:4]}));
            sym.insert(sym.size(), (left > 1) ? int'({b1[3:0], b2[7:6]}) : SYMV_PAD);
            sym.insert(sym.size(), (left > 2) ? int'(b2[5:0]) : SYMV_PAD);
        end
        last_i = sym.size() - 1;

        pick = $urandom_range(99);
        if (pick < 10) begin
            // nonzero leftover bits ahead of the padding, or a raw character if there is none
            if (sym[last_i - 1] == SYMV_PAD) sym[last_i - 2] |= $urandom_range(1, 15);
            else if (sym[last_i] == SYMV_PAD) sym[last_i - 1] |= $urandom_range(1, 3);
            else sym[$urandom_range(last_i)] = SYMV_RAW + $urandom_range(255);
        end else if (pick < 18) begin
            sym[$urandom_range(last_i)] = SYMV_RAW + $urandom_range(255);
        end else if (pick < 24) begin
            // pad anywhere but the final character
            sym[$urandom_range(last_i - 1)] = SYMV_PAD;
        end else if (pick < 31) begin
            // length not a multiple of four
            if ($urandom_range(1) == 1) begin
                cut = $urandom_range(1, 3);
                repeat (cut) void'(sym.pop_back());
            end else begin
                repeat ($urandom_range(1, 3)) sym.insert(sym.size(), $urandom_range(63));
            end
        end

        foreach (sym[k]) begin
            if (sym[k] >= SYMV_RAW) text.insert(text.size(), 8'(sym[k] - SYMV_RAW));
            else if (sym[k] == SYMV_PAD) text.insert(text.size(), "=");
            else text.insert(text.size(), char_for(sym[k]));
        end
    endfunction

    // offer one input word and hold it until accepted
    task automatic send_word(input b64d_in_t w, input logic typed,
                             input logic [STATUS_W-1:0] st);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_word     <= w;
        tag_typed  <= typed;
        tag_status <= st;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait until every owed result word has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // one apb transfer to the size register: setup, access, then idle
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_IDX_MAX, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // access edge: write lands here, read data is valid here
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic readback_max();
        logic [31:0] rd;
        apb_access(1'b0, 32'h0, rd);
        if (rd !== {8'h00, max_bytes}) begin
            errors++;
            $display("%0t: size register readback: expected %0d, got %0d",
                     $time, max_bytes, rd);
        end
    endtask

    task automatic set_max(input logic [MAX_W-1:0] v);
        logic [31:0] rd;
        apb_access(1'b1, {8'h00, v}, rd);
        max_bytes = v;
        readback_max();
    endtask

    // scoreboard: predict on every accepted input word, check every result word
    always @(posedge aclk) begin : scoreboard
        b64d_out_t want;
        b64d_out_t scratch[$];
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : idle_cycles + 1;

            if (s_valid && s_ready) begin
                words_in <= words_in + 1;
                if (tag_typed) begin
                    // typed row: the table says what comes out, predictor just tracks state
                    scratch.delete();
                    decode_char(s_word, scratch);
                    if (s_word.is_last)
                        due_words.insert(due_words.size(),
                                         b64d_out_t'{KIND_STATUS, 8'h00, tag_status, 1'b1});
                end else begin
                    decode_char(s_word, due_words);
                end
            end

            if (m_valid && m_ready) begin
                if (due_words.size() == 0) begin
                    errors++;
                    $display("%0t: result word with none expected: kind=%0d byte=%02h status=%0d last=%0d",
                             $time, m_word.kind, m_word.data_byte, m_word.status, m_word.last);
                end else begin
                    want = due_words.pop_front();
                    if (m_word.kind !== want.kind || m_word.data_byte !== want.data_byte ||
                        m_word.status !== want.status || m_word.last !== want.last) begin
                        errors++;
                        $display("%0t: result word mismatch: expected kind=%0d byte=%02h status=%0d last=%0d",
                                 $time, want.kind, want.data_byte, want.status, want.last);
                        $display("%0t:                        got kind=%0d byte=%02h status=%0d last=%0d",
                                 $time, m_word.kind, m_word.data_byte, m_word.status, m_word.last);
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off so the work queue fills up
    int   hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (!hold_done && words_in >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: too long with no word moving on either channel
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL strict_base64_stream_decoder");
        $finish;
    end

    initial begin
        b64d_in_t          w;
        logic [MAX_W-1:0]  limit_val;
        int                ph, phase_words;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // size register must come out of reset at its default
        readback_max();

        // directed strings at the reset size limit
        foreach (directed_rows[r]) begin
            w.char_code = directed_rows[r].ch;
            w.is_last   = directed_rows[r].lst;
            send_word(w, directed_rows[r].typed, directed_rows[r].st);
        end

        // random strings, one size limit per phase, extremes included
        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       limit_val = 24'd1;
                1:       limit_val = '1;
                2:       limit_val = 24'd2;
                3:       limit_val = MAX_W'($urandom_range(3, 24));
                4:       limit_val = MAX_DECODED_RESET;
                default: limit_val = MAX_W'($urandom_range(1, 40));
            endcase
            set_max(limit_val);
            // one phase runs back to back with no idling on either side
            quiet <= (ph == 1);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                build_string();
                foreach (text[k]) begin
                    w.char_code = text[k];
                    w.is_last   = (k == text.size() - 1);
                    send_word(w, 1'b0, ST_OK);
                end
                phase_words += text.size();
            end
        end

        wait_drained();
        if (errors == 0 && due_words.size() == 0) begin
            $display("PASS strict_base64_stream_decoder");
        end else begin
            $display("FAIL strict_base64_stream_decoder");
        end
        $finish;
    end

endmodule
